>>> hdl/irtt_pkg.sv
// Package for the IOMMU range translation table: sizes, codes, the entry
// layout and the controller states. Depends on nothing else.
`timescale 1ns / 1ps

package irtt_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1) + 1;

  typedef enum logic [1:0] {
    MODE_MAP   = 2'd0,
    MODE_UNMAP = 2'd1,
    MODE_XLATE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_MAPPED = 3'd1,
    ST_PERM       = 3'd2,
    ST_NO_SPLIT   = 3'd3,
    ST_OVERLAP    = 3'd4,
    ST_FULL       = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_SCAN,
    S_MAP_WRITE,
    S_HOLD_SCAN,
    S_UNMAP_CHECK,
    S_NEXT_SCAN,
    S_XL_CALC1,
    S_XL_CALC2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] last;
    logic [63:0] phys;
    logic [1:0]  perm;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> hdl/irtt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
`timescale 1ns / 1ps

module irtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/iommu_range_translation_table.sv
// IOMMU range translation table: top level with the command sequencer.
// Depends on irtt_pkg and irtt_ram.
`timescale 1ns / 1ps

// Commands are handled by scans that read the entry RAM one slot per cycle: map
// and translate scan the table once, unmap may scan again after each removed range.
// One item is in work at a time; the next is taken in the cycle after the result
// moves to the output register.
// Reset clears the valid bits and the control state at once; the entry RAM is not
// cleared and is never read for a free slot.
module iommu_range_translation_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] start_addr_i,
  input  logic [63:0] end_addr_i,
  input  logic [63:0] map_phys_i,
  input  logic [1:0]  perm_i,
  input  logic [31:0] access_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] phys_addr_o,
  output logic [31:0] granted_size_o
);

  import irtt_pkg::*;

  state_e state_q, state_d;

  // Latched command of the item in work.
  mode_e       mode_q, mode_d;
  logic [63:0] s_q, s_d, e_q, e_d, phys_q, phys_d;
  logic [1:0]  perm_q, perm_d;
  logic [31:0] size_q, size_d;

  // Slot occupancy lives in flip-flops so that reset frees the table at once.
  logic [ENTRIES-1:0] valid_q, valid_d;

  // Scan pipeline: cnt_q issues RAM reads, chk_* tags the data returning now.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;

  // The entry found by a scan, and the bound of the next-range search.
  entry_t           ent_q, ent_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic             best_vld_q, best_vld_d;
  logic [63:0]      lo_q, lo_d;
  logic [63:0]      off_q, off_d, span_q, span_d;

  // Result staging and the output register.
  status_e     res_st_q, res_st_d;
  logic [63:0] res_pa_q, res_pa_d;
  logic [31:0] res_gs_q, res_gs_d;
  logic        out_vld_q, out_vld_d;
  status_e     out_st_q, out_st_d;
  logic [63:0] out_pa_q, out_pa_d;
  logic [31:0] out_gs_q, out_gs_d;

  // RAM signals.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  // Lowest free slot.
  logic [IDX_W-1:0] free_idx;
  logic             full;

  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
        full     = 1'b0;
      end
    end
  end

  irtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q[IDX_W-1:0]),
    .rdata_o(rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  assign ram_waddr = free_idx;
  assign ram_wdata = '{first: s_q, last: e_q, phys: phys_q, perm: perm_q};

  // Compare results for the entry coming out of the RAM this cycle.
  logic chk_live, chk_last;
  logic hit_ovl, hit_hold, hit_next;

  assign chk_live = chk_vld_q && valid_q[chk_idx_q];
  assign chk_last = chk_vld_q && (chk_idx_q == IDX_W'(ENTRIES - 1));
  assign hit_ovl  = chk_live && (s_q <= rdata.last) && (rdata.first <= e_q);
  assign hit_hold = chk_live && (rdata.first <= s_q) && (s_q <= rdata.last);
  assign hit_next = chk_live && (rdata.first >= lo_q) &&
                    (!best_vld_q || (rdata.first < ent_q.first));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    s_d        = s_q;
    e_d        = e_q;
    phys_d     = phys_q;
    perm_d     = perm_q;
    size_d     = size_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    ent_d      = ent_q;
    cur_d      = cur_q;
    best_vld_d = best_vld_q;
    lo_d       = lo_q;
    off_d      = off_q;
    span_d     = span_q;
    res_st_d   = res_st_q;
    res_pa_d   = res_pa_q;
    res_gs_d   = res_gs_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_st_d   = out_st_q;
    out_pa_d   = out_pa_q;
    out_gs_d   = out_gs_q;
    ram_we     = 1'b0;

    // Reads are issued for every scan state while slots remain.
    if (state_q == S_MAP_SCAN || state_q == S_HOLD_SCAN || state_q == S_NEXT_SCAN) begin
      if (cnt_q < CNT_W'(ENTRIES)) begin
        cnt_d     = cnt_q + 1'b1;
        chk_vld_d = 1'b1;
        chk_idx_d = cnt_q[IDX_W-1:0];
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_e'(mode_i);
          s_d      = start_addr_i;
          e_d      = end_addr_i;
          phys_d   = map_phys_i;
          perm_d   = perm_i;
          size_d   = access_size_i;
          res_st_d = ST_OK;
          res_pa_d = '0;
          res_gs_d = '0;
          cnt_d    = '0;
          unique case (mode_e'(mode_i))
            MODE_MAP: begin
              if (start_addr_i > end_addr_i) begin
                res_st_d = ST_OVERLAP;
                state_d  = S_DONE;
              end else begin
                state_d = S_MAP_SCAN;
              end
            end
            MODE_UNMAP, MODE_XLATE: state_d = S_HOLD_SCAN;
            default:                state_d = S_DONE;
          endcase
        end
      end

      S_MAP_SCAN: begin
        if (hit_ovl) begin
          res_st_d = ST_OVERLAP;
          state_d  = S_DONE;
        end else if (chk_last) begin
          state_d = S_MAP_WRITE;
        end
      end

      S_MAP_WRITE: begin
        if (full) begin
          res_st_d = ST_FULL;
        end else begin
          ram_we             = 1'b1;
          valid_d[free_idx]  = 1'b1;
        end
        state_d = S_DONE;
      end

      S_HOLD_SCAN: begin
        if (hit_hold) begin
          ent_d   = rdata;
          cur_d   = chk_idx_q;
          state_d = (mode_q == MODE_UNMAP) ? S_UNMAP_CHECK : S_XL_CALC1;
        end else if (chk_last) begin
          res_st_d = ST_NOT_MAPPED;
          state_d  = S_DONE;
        end
      end

      S_UNMAP_CHECK: begin
        if (ent_q.first > e_q) begin
          state_d = S_DONE;
        end else if (ent_q.last > e_q) begin
          res_st_d = ST_NO_SPLIT;
          state_d  = S_DONE;
        end else begin
          valid_d[cur_q] = 1'b0;
          if (&ent_q.last) begin
            state_d = S_DONE;
          end else begin
            // Walk on to the range that starts lowest above this one.
            lo_d       = ent_q.last + 64'd1;
            best_vld_d = 1'b0;
            cnt_d      = '0;
            state_d    = S_NEXT_SCAN;
          end
        end
      end

      S_NEXT_SCAN: begin
        if (hit_next) begin
          ent_d      = rdata;
          cur_d      = chk_idx_q;
          best_vld_d = 1'b1;
        end
        if (chk_last) begin
          state_d = (hit_next || best_vld_q) ? S_UNMAP_CHECK : S_DONE;
        end
      end

      S_XL_CALC1: begin
        if ((perm_q & ~ent_q.perm) != 2'b00) begin
          res_st_d = ST_PERM;
          state_d  = S_DONE;
        end else begin
          off_d   = s_q - ent_q.first;
          span_d  = ent_q.last - s_q;
          state_d = S_XL_CALC2;
        end
      end

      S_XL_CALC2: begin
        // Grant up to the end of the range, at most the requested size.
        res_pa_d = ent_q.phys + off_q;
        if (size_q == 32'd0) begin
          res_gs_d = '0;
        end else if (span_q >= {32'd0, size_q - 32'd1}) begin
          res_gs_d = size_q;
        end else begin
          res_gs_d = span_q[31:0] + 32'd1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_st_d  = res_st_q;
          out_pa_d  = res_pa_q;
          out_gs_d  = res_gs_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      chk_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
      chk_vld_q <= chk_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    s_q        <= s_d;
    e_q        <= e_d;
    phys_q     <= phys_d;
    perm_q     <= perm_d;
    size_q     <= size_d;
    chk_idx_q  <= chk_idx_d;
    ent_q      <= ent_d;
    cur_q      <= cur_d;
    best_vld_q <= best_vld_d;
    lo_q       <= lo_d;
    off_q      <= off_d;
    span_q     <= span_d;
    res_st_q   <= res_st_d;
    res_pa_q   <= res_pa_d;
    res_gs_q   <= res_gs_d;
    out_st_q   <= out_st_d;
    out_pa_q   <= out_pa_d;
    out_gs_q   <= out_gs_d;
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_st_q;
  assign phys_addr_o    = out_pa_q;
  assign granted_size_o = out_gs_q;

endmodule

>>> tb/iommu_range_translation_table_test.sv
// Testbench for the IOMMU range translation table: drives map, unmap and
// translate commands and checks every result against a predictor of its own.
// Depends on irtt_pkg and the iommu_range_translation_table RTL.
`timescale 1ns / 1ps

module iommu_range_translation_table_test;
  import irtt_pkg::*;

  localparam int unsigned NSLOT = ENTRIES;
  localparam int unsigned STALL_LIMIT = 20000;

  // Shape of one expected result.
  typedef struct {
    status_e     status;
    logic [63:0] phys;
    logic [31:0] granted;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [63:0] start_addr_i;
  logic [63:0] end_addr_i;
  logic [63:0] map_phys_i;
  logic [1:0]  perm_i;
  logic [31:0] access_size_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [63:0] phys_addr_o;
  logic [31:0] granted_size_o;

  iommu_range_translation_table dut (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Predicted table contents.
  logic        slot_used [NSLOT];
  logic [63:0] slot_first [NSLOT];
  logic [63:0] slot_last [NSLOT];
  logic [63:0] slot_phys [NSLOT];
  logic [1:0]  slot_perm [NSLOT];

  answer_t pending_answers[$];
  int      mismatch_count;
  int      quiet_cycles;
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      failed;

  // Slot holding the address, or -1 when no range covers it.
  function automatic int holder_of(logic [63:0] addr);
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_used[i] && slot_first[i] <= addr && addr <= slot_last[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Slot of the lowest range starting at or above lo, or -1.
  function automatic int next_above(logic [63:0] lo);
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_used[i] && slot_first[i] >= lo &&
          (best < 0 || slot_first[i] < slot_first[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Applies one command to the predicted table and returns its answer.
  function automatic answer_t apply_command(logic [1:0] mode, logic [63:0] s,
                                            logic [63:0] e, logic [63:0] ph,
                                            logic [1:0] pm, logic [31:0] size);
    answer_t a;
    int free_slot;
    int cur;
    logic [63:0] span;
    logic [63:0] hi;
    bit walking;
    a.status = ST_OK;
    a.phys = '0;
    a.granted = '0;
    case (mode)
      MODE_MAP: begin
        free_slot = -1;
        if (s > e) begin
          a.status = ST_OVERLAP;
        end else begin
          for (int i = 0; i < NSLOT; i++) begin
            if (slot_used[i]) begin
              if (s <= slot_last[i] && slot_first[i] <= e) a.status = ST_OVERLAP;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (a.status == ST_OK && free_slot < 0) a.status = ST_FULL;
          if (a.status == ST_OK) begin
            slot_used[free_slot] = 1'b1;
            slot_first[free_slot] = s;
            slot_last[free_slot] = e;
            slot_phys[free_slot] = ph;
            slot_perm[free_slot] = pm;
          end
        end
      end
      MODE_UNMAP: begin
        cur = holder_of(s);
        if (cur < 0) begin
          a.status = ST_NOT_MAPPED;
        end else begin
          walking = 1'b1;
          for (int n = 0; n < NSLOT && walking && cur >= 0; n++) begin
            hi = slot_last[cur];
            if (slot_first[cur] > e) begin
              walking = 1'b0;
            end else if (hi > e) begin
              a.status = ST_NO_SPLIT;
              walking = 1'b0;
            end else begin
              slot_used[cur] = 1'b0;
              if (hi == '1) walking = 1'b0;
              else cur = next_above(hi + 64'd1);
            end
          end
        end
      end
      MODE_XLATE: begin
        cur = holder_of(s);
        if (cur < 0) begin
          a.status = ST_NOT_MAPPED;
        end else if ((pm & ~slot_perm[cur]) != 2'b00) begin
          a.status = ST_PERM;
        end else begin
          span = slot_last[cur] - s;
          a.phys = slot_phys[cur] + (s - slot_first[cur]);
          if (size == '0) a.granted = '0;
          else if (span >= {32'd0, size} - 64'd1) a.granted = size;
          else a.granted = span[31:0] + 32'd1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Sends one command, with a random gap first, and records its answer.
  // Valid stays high after an accept unless a gap follows, so that back to
  // back items never see two drives of valid in one time step.
  task automatic send_command(logic [1:0] mode, logic [63:0] s, logic [63:0] e,
                              logic [63:0] ph, logic [1:0] pm, logic [31:0] size);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    start_addr_i <= s;
    end_addr_i <= e;
    map_phys_i <= ph;
    perm_i <= pm;
    access_size_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
    pending_answers.push_back(apply_command(mode, s, e, ph, pm, size));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: compares each accepted result with the oldest answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        failed = 1'b1;
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result, status %0d", status_o);
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status || phys_addr_o !== want.phys ||
            granted_size_o !== want.granted) begin
          failed = 1'b1;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected %0d %h %0d, got %0d %h %0d", want.status,
                     want.phys, want.granted, status_o, phys_addr_o, granted_size_o);
          end
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Random address biased into a small window so that ranges collide.
  function automatic logic [63:0] near_addr();
    return ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'(($urandom_range(4095)));
  endfunction

  // Edge cases: full address space ends, inverted range, zero size, bad mode, a full table.
  task automatic test_directed();
    send_command(MODE_XLATE, 64'd0, 64'd0, 64'd0, 2'b01, 32'd4);
    send_command(MODE_UNMAP, 64'd5, 64'd9, 64'd0, 2'b00, 32'd0);
    send_command(MODE_MAP, 64'd10, 64'd5, 64'd0, 2'b11, 32'd0);
    send_command(MODE_MAP, 64'hFFFF_FFFF_FFFF_FF00, '1, '1, 2'b11, '1);
    send_command(MODE_XLATE, '1, 64'd0, 64'd0, 2'b11, '1);
    send_command(MODE_MAP, 64'd0, 64'hFF, 64'hFFFF_FFFF_FFFF_FFF0, 2'b01, 32'd0);
    send_command(MODE_XLATE, 64'h80, '1, '1, 2'b01, 32'd0);
    send_command(MODE_XLATE, 64'h80, 64'd0, 64'd0, 2'b10, 32'd4);
    send_command(MODE_XLATE, 64'hF0, 64'd0, 64'd0, 2'b00, 32'hFFFF_FFFF);
    send_command(MODE_MAP, 64'h50, 64'h150, 64'd0, 2'b11, 32'd0);
    send_command(MODE_MAP, 64'h100, 64'h1FF, 64'h1000, 2'b10, 32'd0);
    send_command(MODE_MAP, 64'h200, 64'h2FF, 64'h2000, 2'b00, 32'd0);
    send_command(MODE_NONE, '1, '1, '1, 2'b11, '1);
    send_command(MODE_UNMAP, 64'h10, 64'h250, 64'd0, 2'b00, 32'd0);
    send_command(MODE_UNMAP, 64'h200, '1, 64'd0, 2'b00, 32'd0);
    send_command(MODE_UNMAP, 64'hFFFF_FFFF_FFFF_FF10, '1, 64'd0, 2'b00, 32'd0);
    for (int i = 0; i < NSLOT + 1; i++) begin
      send_command(MODE_MAP, 64'(i * 16), 64'(i * 16 + 15), 64'(i), 2'b11, 32'd0);
    end
    send_command(MODE_UNMAP, 64'd0, 64'd1000, 64'd0, 2'b00, 32'd0);
    wait_drained();
  endtask

  // Random commands, mostly maps and translates into a crowded window.
  task automatic test_random(int count);
    logic [1:0]  mode;
    logic [63:0] s;
    logic [63:0] e;
    for (int i = 0; i < count; i++) begin
      mode = 2'($urandom_range(9) < 4 ? MODE_MAP : $urandom_range(3));
      s = near_addr();
      e = ($urandom_range(7) == 0) ? {$urandom, $urandom} : s + $urandom_range(300);
      send_command(mode, s, e, {$urandom, $urandom}, 2'($urandom), $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = '0;
    start_addr_i = '0;
    end_addr_i = '0;
    map_phys_i = '0;
    perm_i = '0;
    access_size_i = '0;
    for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(250);
    send_idle_pct = 70;
    test_random(250);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 70;
    test_random(250);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_random(250);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (!failed && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
